[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the disc collision checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_IMPLY_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

// next-cycle implication, checked during reset too
`define ASSERT_ALWAYS_NEXT(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("assertion failed");

`endif

[rtl/cdr_pkg.sv]
// ---------------------------------------------------------------------------
// cdr_pkg
// Types, constants and rounding helpers for the disc collision pipeline.
// ---------------------------------------------------------------------------
package cdr_pkg;

    localparam int FW     = 24;
    localparam int DW     = FW + 1;
    localparam int NW     = 18;
    localparam int STEPS  = 17;
    localparam int RAD_W  = 16;
    localparam int RES_W  = 13;
    localparam int CFG_W  = 16;

    localparam logic CFG_DISC_RADIUS = 1'b0;
    localparam logic CFG_RESTITUTION = 1'b1;

    localparam logic [RAD_W-1:0] RADIUS_RESET      = 16'd1638;
    localparam logic [RES_W-1:0] RESTITUTION_RESET = 13'd3686;

    typedef logic signed [FW-1:0] fld_t;
    typedef logic signed [DW-1:0] dlt_t;
    typedef logic signed [NW-1:0] nrm_t;

    typedef struct packed {
        fld_t first_pos_x;
        fld_t first_pos_z;
        fld_t first_vel_x;
        fld_t first_vel_z;
        fld_t second_pos_x;
        fld_t second_pos_z;
        fld_t second_vel_x;
        fld_t second_vel_z;
    } in_item_t;

    typedef struct packed {
        fld_t new_first_pos_x;
        fld_t new_first_pos_z;
        fld_t new_first_vel_x;
        fld_t new_first_vel_z;
        fld_t new_second_pos_x;
        fld_t new_second_pos_z;
        fld_t new_second_vel_x;
        fld_t new_second_vel_z;
        logic impact_applied;
    } out_item_t;

    typedef struct packed {
        in_item_t pair;
        logic     coll;
        dlt_t     dx;
        dlt_t     dz;
        dlt_t     dvx;
        dlt_t     dvz;
    } ctx_t;

    function automatic logic signed [31:0] rnd_sh32(input logic signed [62:0] v);
        logic [62:0] mag;
        logic [62:0] m;
        mag = v[62] ? 63'(-v) : 63'(v);
        m   = (mag + (63'd1 << 31)) >> 32;
        return v[62] ? -$signed(m[31:0]) : $signed(m[31:0]);
    endfunction

    function automatic logic signed [31:0] rnd_sh17(input logic signed [35:0] v);
        logic [35:0] mag;
        logic [35:0] m;
        mag = v[35] ? 36'(-v) : 36'(v);
        m   = (mag + (36'd1 << 16)) >> 17;
        return v[35] ? -$signed(m[31:0]) : $signed(m[31:0]);
    endfunction

    function automatic fld_t sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607)
            return 24'sh7FFFFF;
        else if (v < -32'sd8388608)
            return 24'sh800000;
        else
            return v[FW-1:0];
    endfunction

endpackage

[rtl/cdr_if.sv]
// ---------------------------------------------------------------------------
// cdr_if
// Valid/ready channels for disc pair requests and collision results.
// ---------------------------------------------------------------------------
interface cdr_in_if;
    logic             valid;
    logic             ready;
    cdr_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cdr_out_if;
    logic              valid;
    logic              ready;
    cdr_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/cdr_sqrt.sv]
// ---------------------------------------------------------------------------
// cdr_sqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module cdr_sqrt
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_vld,
    input  cdr_pkg::ctx_t in_ctx,
    input  logic [33:0]   in_rad,
    output logic          out_vld,
    output cdr_pkg::ctx_t out_ctx,
    output logic [16:0]   out_dist
);

    logic          vld_reg  [cdr_pkg::STEPS];
    cdr_pkg::ctx_t ctx_reg  [cdr_pkg::STEPS];
    logic [19:0]   rem_reg  [cdr_pkg::STEPS];
    logic [16:0]   root_reg [cdr_pkg::STEPS];
    logic [33:0]   rad_reg  [cdr_pkg::STEPS];

    for (genvar k = 0; k < cdr_pkg::STEPS; k++)
    begin : g_stage
        logic          s_vld;
        cdr_pkg::ctx_t s_ctx;
        logic [19:0]   s_rem;
        logic [16:0]   s_root;
        logic [33:0]   s_rad;
        logic [19:0]   r;
        logic [19:0]   trial;
        logic [19:0]   rem_next;
        logic [16:0]   root_next;

        if (k == 0)
        begin : g_first
            assign s_vld  = in_vld;
            assign s_ctx  = in_ctx;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rad  = in_rad;
        end
        else
        begin : g_rest
            assign s_vld  = vld_reg[k-1];
            assign s_ctx  = ctx_reg[k-1];
            assign s_rem  = rem_reg[k-1];
            assign s_root = root_reg[k-1];
            assign s_rad  = rad_reg[k-1];
        end

        always_comb
        begin
            r     = {s_rem[17:0], s_rad[33:32]};
            trial = {1'b0, s_root, 2'b01};
            if (r >= trial)
            begin
                rem_next  = r - trial;
                root_next = {s_root[15:0], 1'b1};
            end
            else
            begin
                rem_next  = r;
                root_next = {s_root[15:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= s_vld;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctx_reg[k]  <= s_ctx;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {s_rad[31:0], 2'b00};
            end
        end
    end

    assign out_vld  = vld_reg[cdr_pkg::STEPS-1];
    assign out_ctx  = ctx_reg[cdr_pkg::STEPS-1];
    assign out_dist = root_reg[cdr_pkg::STEPS-1];

endmodule

[rtl/cdr_div.sv]
// ---------------------------------------------------------------------------
// cdr_div
// Pipelined restoring divider for the unit normal, both axes in parallel.
// ---------------------------------------------------------------------------
module cdr_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_vld,
    input  cdr_pkg::ctx_t in_ctx,
    input  logic [16:0]   in_dist,
    output logic          out_vld,
    output cdr_pkg::ctx_t out_ctx,
    output logic [16:0]   out_dist,
    output cdr_pkg::nrm_t out_nx,
    output cdr_pkg::nrm_t out_nz
);

    logic          vld_reg  [cdr_pkg::STEPS];
    cdr_pkg::ctx_t ctx_reg  [cdr_pkg::STEPS];
    logic [16:0]   dist_reg [cdr_pkg::STEPS];
    logic [17:0]   remx_reg [cdr_pkg::STEPS];
    logic [17:0]   remz_reg [cdr_pkg::STEPS];
    logic [16:0]   qx_reg   [cdr_pkg::STEPS];
    logic [16:0]   qz_reg   [cdr_pkg::STEPS];

    cdr_pkg::dlt_t ax;
    cdr_pkg::dlt_t az;

    assign ax = in_ctx.dx[cdr_pkg::DW-1] ? -in_ctx.dx : in_ctx.dx;
    assign az = in_ctx.dz[cdr_pkg::DW-1] ? -in_ctx.dz : in_ctx.dz;

    for (genvar k = 0; k < cdr_pkg::STEPS; k++)
    begin : g_stage
        logic          s_vld;
        cdr_pkg::ctx_t s_ctx;
        logic [16:0]   s_dist;
        logic [17:0]   s_remx;
        logic [17:0]   s_remz;
        logic [16:0]   s_qx;
        logic [16:0]   s_qz;
        logic          s_bx;
        logic          s_bz;
        logic [18:0]   rx;
        logic [18:0]   rz;
        logic          gex;
        logic          gez;

        if (k == 0)
        begin : g_first
            assign s_vld  = in_vld;
            assign s_ctx  = in_ctx;
            assign s_dist = in_dist;
            assign s_remx = {1'b0, ax[17:1]};
            assign s_remz = {1'b0, az[17:1]};
            assign s_qx   = '0;
            assign s_qz   = '0;
            assign s_bx   = ax[0];
            assign s_bz   = az[0];
        end
        else
        begin : g_rest
            assign s_vld  = vld_reg[k-1];
            assign s_ctx  = ctx_reg[k-1];
            assign s_dist = dist_reg[k-1];
            assign s_remx = remx_reg[k-1];
            assign s_remz = remz_reg[k-1];
            assign s_qx   = qx_reg[k-1];
            assign s_qz   = qz_reg[k-1];
            assign s_bx   = 1'b0;
            assign s_bz   = 1'b0;
        end

        assign rx  = {s_remx, s_bx};
        assign rz  = {s_remz, s_bz};
        assign gex = rx >= {2'b00, s_dist};
        assign gez = rz >= {2'b00, s_dist};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= s_vld;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctx_reg[k]  <= s_ctx;
                dist_reg[k] <= s_dist;
                remx_reg[k] <= gex ? 18'(rx - {2'b00, s_dist}) : rx[17:0];
                remz_reg[k] <= gez ? 18'(rz - {2'b00, s_dist}) : rz[17:0];
                qx_reg[k]   <= {s_qx[15:0], gex};
                qz_reg[k]   <= {s_qz[15:0], gez};
            end
        end
    end

    localparam int L = cdr_pkg::STEPS - 1;

    assign out_vld  = vld_reg[L];
    assign out_ctx  = ctx_reg[L];
    assign out_dist = dist_reg[L];
    assign out_nx   = ctx_reg[L].dx[cdr_pkg::DW-1] ? -$signed({1'b0, qx_reg[L]})
                                                   : $signed({1'b0, qx_reg[L]});
    assign out_nz   = ctx_reg[L].dz[cdr_pkg::DW-1] ? -$signed({1'b0, qz_reg[L]})
                                                   : $signed({1'b0, qz_reg[L]});

endmodule

[rtl/cdr_apply.sv]
// ---------------------------------------------------------------------------
// cdr_apply
// Relative speed, impulse and separation, then saturation into the result.
// ---------------------------------------------------------------------------
module cdr_apply
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic [cdr_pkg::RES_W-1:0]    restitution,
    input  logic [16:0]                  twor,
    input  logic                         in_vld,
    input  cdr_pkg::ctx_t                in_ctx,
    input  logic [16:0]                  in_dist,
    input  cdr_pkg::nrm_t                in_nx,
    input  cdr_pkg::nrm_t                in_nz,
    output logic                         out_vld,
    output cdr_pkg::out_item_t           out_item
);

    logic                  a1_vld_reg, a2_vld_reg, a3_vld_reg;
    logic                  a4_vld_reg, a5_vld_reg, a6_vld_reg;
    cdr_pkg::in_item_t     a1_pair_reg, a2_pair_reg, a3_pair_reg, a4_pair_reg, a5_pair_reg;
    logic                  a1_coll_reg;
    logic                  a2_hit_reg, a3_hit_reg, a4_hit_reg, a5_hit_reg;
    cdr_pkg::nrm_t         a1_nx_reg, a1_nz_reg, a2_nx_reg, a2_nz_reg;
    cdr_pkg::nrm_t         a3_nx_reg, a3_nz_reg;
    logic signed [42:0]    a1_mx_reg, a1_mz_reg;
    logic signed [17:0]    a1_ov_reg;
    logic [42:0]           a2_negp_reg;
    logic signed [35:0]    a2_ovx_reg, a2_ovz_reg;
    logic [56:0]           a3_q_reg;
    logic signed [31:0]    a3_sx_reg, a3_sz_reg, a4_sx_reg, a4_sz_reg, a5_sx_reg, a5_sz_reg;
    logic signed [62:0]    a4_jx_reg, a4_jz_reg;
    logic signed [31:0]    a5_ix_reg, a5_iz_reg;
    cdr_pkg::out_item_t    a6_item_reg;

    logic signed [43:0]    p_next;
    logic signed [44:0]    j_next;
    cdr_pkg::out_item_t    item_next;

    assign p_next = 44'(a1_mx_reg) + 44'(a1_mz_reg);
    assign j_next = $signed({1'b0, a3_q_reg[56:13]});

    always_comb
    begin
        item_next.new_first_pos_x  = a5_pair_reg.first_pos_x;
        item_next.new_first_pos_z  = a5_pair_reg.first_pos_z;
        item_next.new_first_vel_x  = a5_pair_reg.first_vel_x;
        item_next.new_first_vel_z  = a5_pair_reg.first_vel_z;
        item_next.new_second_pos_x = a5_pair_reg.second_pos_x;
        item_next.new_second_pos_z = a5_pair_reg.second_pos_z;
        item_next.new_second_vel_x = a5_pair_reg.second_vel_x;
        item_next.new_second_vel_z = a5_pair_reg.second_vel_z;
        item_next.impact_applied   = a5_hit_reg;
        if (a5_hit_reg)
        begin
            item_next.new_first_pos_x  = cdr_pkg::sat24(32'(a5_pair_reg.first_pos_x) - a5_sx_reg);
            item_next.new_first_pos_z  = cdr_pkg::sat24(32'(a5_pair_reg.first_pos_z) - a5_sz_reg);
            item_next.new_first_vel_x  = cdr_pkg::sat24(32'(a5_pair_reg.first_vel_x) - a5_ix_reg);
            item_next.new_first_vel_z  = cdr_pkg::sat24(32'(a5_pair_reg.first_vel_z) - a5_iz_reg);
            item_next.new_second_pos_x = cdr_pkg::sat24(32'(a5_pair_reg.second_pos_x) + a5_sx_reg);
            item_next.new_second_pos_z = cdr_pkg::sat24(32'(a5_pair_reg.second_pos_z) + a5_sz_reg);
            item_next.new_second_vel_x = cdr_pkg::sat24(32'(a5_pair_reg.second_vel_x) + a5_ix_reg);
            item_next.new_second_vel_z = cdr_pkg::sat24(32'(a5_pair_reg.second_vel_z) + a5_iz_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_vld_reg <= 1'b0;
            a2_vld_reg <= 1'b0;
            a3_vld_reg <= 1'b0;
            a4_vld_reg <= 1'b0;
            a5_vld_reg <= 1'b0;
            a6_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a1_vld_reg <= in_vld;
            a2_vld_reg <= a1_vld_reg;
            a3_vld_reg <= a2_vld_reg;
            a4_vld_reg <= a3_vld_reg;
            a5_vld_reg <= a4_vld_reg;
            a6_vld_reg <= a5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_pair_reg <= in_ctx.pair;
            a1_coll_reg <= in_ctx.coll;
            a1_nx_reg   <= in_nx;
            a1_nz_reg   <= in_nz;
            a1_mx_reg   <= 43'(in_ctx.dvx * in_nx);
            a1_mz_reg   <= 43'(in_ctx.dvz * in_nz);
            a1_ov_reg   <= $signed({1'b0, twor}) - $signed({1'b0, in_dist});

            a2_pair_reg <= a1_pair_reg;
            a2_hit_reg  <= a1_coll_reg && (p_next <= 44'sd0);
            a2_negp_reg <= 43'(-p_next);
            a2_nx_reg   <= a1_nx_reg;
            a2_nz_reg   <= a1_nz_reg;
            a2_ovx_reg  <= 36'(a1_ov_reg * a1_nx_reg);
            a2_ovz_reg  <= 36'(a1_ov_reg * a1_nz_reg);

            a3_pair_reg <= a2_pair_reg;
            a3_hit_reg  <= a2_hit_reg;
            a3_nx_reg   <= a2_nx_reg;
            a3_nz_reg   <= a2_nz_reg;
            a3_q_reg    <= 57'(a2_negp_reg * (14'd4096 + 14'(restitution)));
            a3_sx_reg   <= cdr_pkg::rnd_sh17(a2_ovx_reg);
            a3_sz_reg   <= cdr_pkg::rnd_sh17(a2_ovz_reg);

            a4_pair_reg <= a3_pair_reg;
            a4_hit_reg  <= a3_hit_reg;
            a4_sx_reg   <= a3_sx_reg;
            a4_sz_reg   <= a3_sz_reg;
            a4_jx_reg   <= 63'(j_next * a3_nx_reg);
            a4_jz_reg   <= 63'(j_next * a3_nz_reg);

            a5_pair_reg <= a4_pair_reg;
            a5_hit_reg  <= a4_hit_reg;
            a5_sx_reg   <= a4_sx_reg;
            a5_sz_reg   <= a4_sz_reg;
            a5_ix_reg   <= cdr_pkg::rnd_sh32(a4_jx_reg);
            a5_iz_reg   <= cdr_pkg::rnd_sh32(a4_jz_reg);

            a6_item_reg <= item_next;
        end
    end

    assign out_vld  = a6_vld_reg;
    assign out_item = a6_item_reg;

endmodule

[rtl/disc_collision_response.sv]
// ---------------------------------------------------------------------------
// disc_collision_response
// Equal-mass disc pair collision response with restitution, fully pipelined.
// ---------------------------------------------------------------------------
// Throughput: one request per cycle while results are not stalled; the 17-stage
// square root and the 17-stage normal divider each retire one bit per stage.
// A stalled result register holds the whole pipeline in place.
// Reset clears all valid bits; disc_radius resets to 1638, restitution to 3686.
module disc_collision_response
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [cdr_pkg::CFG_W-1:0]   cfg_data,
    cdr_in_if.sink                      pairs,
    cdr_out_if.source                   results
);

    logic [cdr_pkg::RAD_W-1:0] radius_reg;
    logic [cdr_pkg::RES_W-1:0] rest_reg;
    logic [33:0]               twor_sq_reg;
    logic [16:0]               twor;
    logic                      adv;

    logic                      f0_vld_reg, f1_vld_reg, f2_vld_reg;
    cdr_pkg::ctx_t             f0_ctx_reg, f1_ctx_reg, f2_ctx_reg;
    logic [48:0]               f1_dxsq_reg, f1_dzsq_reg;
    logic [33:0]               f2_rad_reg;
    cdr_pkg::ctx_t             f0_ctx_next;
    cdr_pkg::ctx_t             f2_ctx_next;
    logic [49:0]               dist2;

    logic                      sq_vld;
    cdr_pkg::ctx_t             sq_ctx;
    logic [16:0]               sq_dist;
    logic                      dv_vld;
    cdr_pkg::ctx_t             dv_ctx;
    logic [16:0]               dv_dist;
    cdr_pkg::nrm_t             dv_nx;
    cdr_pkg::nrm_t             dv_nz;

    assign twor          = {radius_reg, 1'b0};
    assign adv           = !results.valid || results.ready;
    assign pairs.ready   = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= cdr_pkg::RADIUS_RESET;
            rest_reg   <= cdr_pkg::RESTITUTION_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cdr_pkg::CFG_DISC_RADIUS: radius_reg <= cfg_data;
                cdr_pkg::CFG_RESTITUTION: rest_reg   <= cfg_data[cdr_pkg::RES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        twor_sq_reg <= 34'(twor * twor);
    end

    always_comb
    begin
        f0_ctx_next.pair = pairs.data;
        f0_ctx_next.coll = 1'b0;
        f0_ctx_next.dx   = 25'(pairs.data.second_pos_x) - 25'(pairs.data.first_pos_x);
        f0_ctx_next.dz   = 25'(pairs.data.second_pos_z) - 25'(pairs.data.first_pos_z);
        f0_ctx_next.dvx  = 25'(pairs.data.second_vel_x) - 25'(pairs.data.first_vel_x);
        f0_ctx_next.dvz  = 25'(pairs.data.second_vel_z) - 25'(pairs.data.first_vel_z);
    end

    assign dist2 = {1'b0, f1_dxsq_reg} + {1'b0, f1_dzsq_reg};

    always_comb
    begin
        f2_ctx_next      = f1_ctx_reg;
        f2_ctx_next.coll = (dist2 != '0) && (dist2 < {16'b0, twor_sq_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_vld_reg <= 1'b0;
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f0_vld_reg <= pairs.valid;
            f1_vld_reg <= f0_vld_reg;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f0_ctx_reg       <= f0_ctx_next;
            f1_ctx_reg       <= f0_ctx_reg;
            f1_dxsq_reg      <= 49'(f0_ctx_reg.dx * f0_ctx_reg.dx);
            f1_dzsq_reg      <= 49'(f0_ctx_reg.dz * f0_ctx_reg.dz);
            f2_ctx_reg       <= f2_ctx_next;
            f2_rad_reg       <= dist2[33:0];
        end
    end

    cdr_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (f2_vld_reg),
        .in_ctx   (f2_ctx_reg),
        .in_rad   (f2_rad_reg),
        .out_vld  (sq_vld),
        .out_ctx  (sq_ctx),
        .out_dist (sq_dist)
    );

    cdr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (sq_vld),
        .in_ctx   (sq_ctx),
        .in_dist  (sq_dist),
        .out_vld  (dv_vld),
        .out_ctx  (dv_ctx),
        .out_dist (dv_dist),
        .out_nx   (dv_nx),
        .out_nz   (dv_nz)
    );

    cdr_apply u_apply
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .restitution (rest_reg),
        .twor        (twor),
        .in_vld      (dv_vld),
        .in_ctx      (dv_ctx),
        .in_dist     (dv_dist),
        .in_nx       (dv_nx),
        .in_nz       (dv_nz),
        .out_vld     (results.valid),
        .out_item    (results.data)
    );

endmodule

[rtl/cdr_checker.sv]
// ---------------------------------------------------------------------------
// cdr_checker
// Port-level checks on the request and result channels.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cdr_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  cdr_pkg::out_item_t out_data
);

    `ASSERT_IMPLY(a_ready_follows_output, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))
    `ASSERT_ALWAYS_NEXT(a_no_result_after_reset, clk, !rst_n, !out_valid)
    `ASSERT_IMPLY_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_IMPLY_NEXT(a_payload_held, clk, rst_n, out_valid && !out_ready, $stable(out_data))

endmodule

bind disc_collision_response cdr_checker u_cdr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pairs.valid),
    .in_ready  (pairs.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Disc collision response testbench
// Sends disc pair requests through a valid/ready channel with random gaps on
// both sides, predicts each collision result from its own fixed-point model
// of the impulse and separation math, and checks every result field in order.
// ---------------------------------------------------------------------------
module testbench;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [cdr_pkg::CFG_W-1:0] cfg_data;

    cdr_in_if  pairs();
    cdr_out_if results();

    disc_collision_response dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pairs     (pairs.sink),
        .results   (results.source)
    );

    localparam longint FMAX = 8388607;
    localparam longint FMIN = -8388608;

    longint             radius_q;
    longint             resti_q;
    cdr_pkg::out_item_t pending_results[$];
    int                 error_count;
    int                 request_count;
    int                 result_count;
    int                 contact_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint round_away(longint v, int s);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic cdr_pkg::fld_t clip24(longint v);
        if (v > FMAX)
            return cdr_pkg::fld_t'(FMAX);
        if (v < FMIN)
            return cdr_pkg::fld_t'(FMIN);
        return cdr_pkg::fld_t'(v);
    endfunction

    function automatic longint floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= root + b)
            begin
                x = x - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return longint'(root);
    endfunction

    function automatic cdr_pkg::out_item_t resolve_pair(cdr_pkg::in_item_t p);
        longint px1, pz1, vx1, vz1, px2, pz2, vx2, vz2;
        longint dx, dz, d2, tw, dlen, nx, nz, along, jmp, ix, iz, ov, sx, sz;
        longint unsigned q;
        cdr_pkg::out_item_t r;
        px1 = p.first_pos_x;  pz1 = p.first_pos_z;
        vx1 = p.first_vel_x;  vz1 = p.first_vel_z;
        px2 = p.second_pos_x; pz2 = p.second_pos_z;
        vx2 = p.second_vel_x; vz2 = p.second_vel_z;
        r.impact_applied = 1'b0;
        dx = px2 - px1;
        dz = pz2 - pz1;
        d2 = dx * dx + dz * dz;
        tw = 2 * radius_q;
        if (d2 != 0 && d2 < tw * tw)
        begin
            dlen = floor_sqrt(d2);
            nx = (dx * 65536) / dlen;
            nz = (dz * 65536) / dlen;
            along = (vx2 - vx1) * nx + (vz2 - vz1) * nz;
            if (along <= 0)
            begin
                q = longint'(-along) * (4096 + resti_q);
                jmp = longint'(q >> 13);
                ix = round_away(jmp * nx, 32);
                iz = round_away(jmp * nz, 32);
                ov = tw - dlen;
                sx = round_away(ov * nx, 17);
                sz = round_away(ov * nz, 17);
                vx1 -= ix; vz1 -= iz; vx2 += ix; vz2 += iz;
                px1 -= sx; pz1 -= sz; px2 += sx; pz2 += sz;
                r.impact_applied = 1'b1;
            end
        end
        r.new_first_pos_x  = clip24(px1);
        r.new_first_pos_z  = clip24(pz1);
        r.new_first_vel_x  = clip24(vx1);
        r.new_first_vel_z  = clip24(vz1);
        r.new_second_pos_x = clip24(px2);
        r.new_second_pos_z = clip24(pz2);
        r.new_second_vel_x = clip24(vx2);
        r.new_second_vel_z = clip24(vz2);
        return r;
    endfunction

    function automatic cdr_pkg::in_item_t make_pair(longint a, longint b, longint c,
                                                    longint d, longint e, longint f,
                                                    longint g, longint h);
        cdr_pkg::in_item_t p;
        p.first_pos_x  = cdr_pkg::fld_t'(a); p.first_pos_z  = cdr_pkg::fld_t'(b);
        p.first_vel_x  = cdr_pkg::fld_t'(c); p.first_vel_z  = cdr_pkg::fld_t'(d);
        p.second_pos_x = cdr_pkg::fld_t'(e); p.second_pos_z = cdr_pkg::fld_t'(f);
        p.second_vel_x = cdr_pkg::fld_t'(g); p.second_vel_z = cdr_pkg::fld_t'(h);
        return p;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pair(cdr_pkg::in_item_t p);
        int gap;
        pairs.valid <= 1'b1;
        pairs.data  <= p;
        forever
        begin
            @(negedge clk);
            if (pairs.ready)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        pending_results.push_back(resolve_pair(p));
        request_count++;
        gap = pick_gap();
        if (gap > 0)
        begin
            pairs.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_register(logic idx, longint value);
        pairs.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= cdr_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == cdr_pkg::CFG_DISC_RADIUS)
            radius_q = value & 16'hFFFF;
        else
            resti_q = value & 13'h1FFF;
    endtask

    function automatic longint rand_full();
        return longint'($signed(24'($urandom)));
    endfunction

    function automatic longint rand_near(longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic cdr_pkg::in_item_t contact_pair();
        longint x1, z1, span, vs;
        span = 2 * radius_q + 4;
        x1 = rand_near(8388607 - 262200);
        z1 = rand_near(8388607 - 262200);
        vs = ($urandom_range(0, 3) == 0) ? 8388607 : 65536;
        return make_pair(x1, z1, rand_near(vs), rand_near(vs),
                         x1 + rand_near(span), z1 + rand_near(span),
                         rand_near(vs), rand_near(vs));
    endfunction

    task automatic run_passthrough_cases();
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(FMAX, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX));
        send_pair(make_pair(FMIN, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN));
        send_pair(make_pair(FMIN, FMAX, FMAX, FMIN, FMAX, FMIN, FMIN, FMAX));
        send_pair(make_pair(0, 0, -4096, 0, 2048, 0, 4096, 0));
        send_pair(make_pair(0, 0, 0, 0, 3276, 0, 0, 0));
    endtask

    task automatic run_contact_cases();
        send_pair(make_pair(0, 0, 4096, 0, 2048, 0, -4096, 0));
        send_pair(make_pair(0, 0, 777, -300, 1000, -1500, 777, -300));
        send_pair(make_pair(0, 0, 0, 0, 3275, 0, 0, 0));
        send_pair(make_pair(100, 200, 5000, 9000, 1100, -1300, -7000, 300));
        send_pair(make_pair(FMIN, 0, FMAX, 0, FMIN + 1000, 0, FMIN, 0));
        send_pair(make_pair(FMAX - 500, FMAX, FMAX, FMAX, FMAX, FMAX - 1, FMIN, FMIN));
        send_pair(make_pair(0, 0, 0, 1, 0, 1, 0, 0));
    endtask

    task automatic run_restitution_extremes();
        set_register(cdr_pkg::CFG_RESTITUTION, 8191);
        send_pair(make_pair(0, 0, 4096, 100, 1500, 700, -4096, -30));
        send_pair(make_pair(0, 0, FMAX, FMAX, 2, 1, FMIN, FMIN));
        set_register(cdr_pkg::CFG_RESTITUTION, 0);
        send_pair(make_pair(0, 0, 4096, 100, 1500, 700, -4096, -30));
        set_register(cdr_pkg::CFG_RESTITUTION, 4096);
        send_pair(make_pair(0, 0, 4096, 100, -1500, 700, -4096, -30));
    endtask

    task automatic run_radius_extremes();
        set_register(cdr_pkg::CFG_DISC_RADIUS, 65535);
        send_pair(make_pair(0, 0, 4096, 0, 131069, 0, -4096, 0));
        send_pair(make_pair(0, 0, 4096, 0, 131070, 0, -4096, 0));
        set_register(cdr_pkg::CFG_DISC_RADIUS, 0);
        send_pair(make_pair(0, 0, 4096, 0, 1, 0, -4096, 0));
    endtask

    task automatic run_random_pairs(int count, longint radius, longint resti);
        set_register(cdr_pkg::CFG_DISC_RADIUS, radius);
        set_register(cdr_pkg::CFG_RESTITUTION, resti);
        repeat (count)
        begin
            if ($urandom_range(0, 4) == 0)
                send_pair(make_pair(rand_full(), rand_full(), rand_full(), rand_full(),
                                    rand_full(), rand_full(), rand_full(), rand_full()));
            else
                send_pair(contact_pair());
        end
    endtask

    initial
    begin
        int stall;
        stall = 0;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                results.ready <= 1'b0;
            end
            else
            begin
                stall = pick_gap();
                results.ready <= (stall == 0);
            end
        end
    end

    task automatic check_field(string name, cdr_pkg::fld_t exp_v, cdr_pkg::fld_t act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cdr_pkg::out_item_t want;
        cdr_pkg::out_item_t got;
        if (rst_n && results.valid && results.ready)
        begin
            got = results.data;
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("result with no pending request");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("new_first_pos_x", want.new_first_pos_x, got.new_first_pos_x);
                check_field("new_first_pos_z", want.new_first_pos_z, got.new_first_pos_z);
                check_field("new_first_vel_x", want.new_first_vel_x, got.new_first_vel_x);
                check_field("new_first_vel_z", want.new_first_vel_z, got.new_first_vel_z);
                check_field("new_second_pos_x", want.new_second_pos_x,
                            got.new_second_pos_x);
                check_field("new_second_pos_z", want.new_second_pos_z,
                            got.new_second_pos_z);
                check_field("new_second_vel_x", want.new_second_vel_x,
                            got.new_second_vel_x);
                check_field("new_second_vel_z", want.new_second_vel_z,
                            got.new_second_vel_z);
                if (want.impact_applied !== got.impact_applied)
                begin
                    $error("impact_applied: expected %0d, got %0d",
                           want.impact_applied, got.impact_applied);
                    error_count++;
                end
                if (want.impact_applied)
                    contact_count++;
            end
        end
    end

    initial
    begin
        error_count   = 0;
        request_count = 0;
        result_count  = 0;
        contact_count = 0;
        radius_q      = 1638;
        resti_q       = 3686;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = cdr_pkg::CFG_DISC_RADIUS;
        cfg_data      = '0;
        pairs.valid   = 1'b0;
        pairs.data    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_passthrough_cases();
        run_contact_cases();
        run_restitution_extremes();
        run_radius_extremes();
        run_random_pairs(250, 1638, 3686);
        run_random_pairs(150, 65535, 8191);
        run_random_pairs(50, 0, 0);
        run_random_pairs(150, 4096, 4096);
        run_random_pairs(200, $urandom_range(1, 20000), $urandom_range(0, 8191));

        pairs.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Covered %0d disc pair requests, %0d results, %0d with impact applied,",
                 request_count, result_count, contact_count);
        $display("across radius and restitution settings including both extremes.");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
